### rtl/rpw_pkg.sv
// Shared types, constants and helper functions of the rotated palette pixel writer.
`default_nettype none

package rpw_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int COORD_BITS    = 12;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int POS_W         = 12;
  localparam int IDX_W         = 8;
  localparam int COORD_USE     = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int PADDR_W       = 5;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_DRAW    = 1'b1;

  typedef enum logic [2:0] {
    REG_ROTATION     = 3'd0,
    REG_LOG_WIDTH    = 3'd1,
    REG_LOG_HEIGHT   = 3'd2,
    REG_BPP          = 3'd3,
    REG_ROW_STRIDE   = 3'd4,
    REG_RED_FORMAT   = 3'd5,
    REG_GREEN_FORMAT = 3'd6,
    REG_BLUE_FORMAT  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  localparam logic [1:0]  RST_ROTATION     = 2'd0;
  localparam logic [12:0] RST_LOG_WIDTH    = 13'd320;
  localparam logic [12:0] RST_LOG_HEIGHT   = 13'd240;
  localparam logic [2:0]  RST_BPP          = 3'd2;
  localparam logic [14:0] RST_ROW_STRIDE   = 15'd640;
  localparam logic [8:0]  RST_RED_FORMAT   = 9'd181;
  localparam logic [8:0]  RST_GREEN_FORMAT = 9'd86;
  localparam logic [8:0]  RST_BLUE_FORMAT  = 9'd5;

  typedef struct packed {
    logic [1:0]  rotation;
    logic [12:0] logical_width;
    logic [12:0] logical_height;
    logic [2:0]  bytes_per_pixel;
    logic [14:0] row_stride;
    logic [8:0]  red_format;
    logic [8:0]  green_format;
    logic [8:0]  blue_format;
  } cfg_t;

  // Front-end decode of one item.
  typedef struct packed {
    logic        pal_we;
    logic [31:0] pal_wdata;
    logic        hit;
    logic [12:0] row;
    logic [12:0] col;
  } front_t;

  // Item held between the input register and the result register.
  typedef struct packed {
    logic        kind;
    logic        hit;
    logic [12:0] row;
    logic [12:0] col;
    logic        xor_mode;
    logic [31:0] wdata;
  } stage_t;

  function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
    logic [2:0] r;
    case (bpp)
      3'd2, 3'd3, 3'd4: r = bpp;
      default:          r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] bpp);
    logic [31:0] m;
    case (bpp)
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      3'd4:    m = 32'hffff_ffff;
      default: m = 32'h0000_00ff;
    endcase
    return m;
  endfunction

  // One color component: top len bits of the 8-bit value, placed at offset.
  function automatic logic [31:0] pack_component(input logic [7:0] comp,
                                                 input logic [8:0] fmt);
    logic [3:0] len;
    logic [4:0] off;
    logic [7:0] v;
    len = fmt[3:0];
    off = fmt[8:4];
    if (len > 4'd8) len = 4'd8;
    v = comp >> (4'd8 - len);
    if (len == 4'd0) v = 8'd0;
    return {24'd0, v} << off;
  endfunction

  // Sign-extend the low COORD_USE bits, result one bit wider than the field.
  function automatic logic [POS_W:0] coord_value(input logic [POS_W-1:0] raw);
    logic [POS_W-1:0] m;
    m = raw;
    for (int i = 0; i < POS_W; i++) begin
      if (i >= COORD_USE) m[i] = raw[COORD_USE-1];
    end
    return {m[POS_W-1], m};
  endfunction

endpackage

`default_nettype wire

### rtl/rpw_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module rpw_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rpw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rpw_pkg::cfg_t              cfg
);

  logic             wr;
  rpw_pkg::reg_idx_t sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = rpw_pkg::reg_idx_t'(paddr[rpw_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation        <= rpw_pkg::RST_ROTATION;
      cfg.logical_width   <= rpw_pkg::RST_LOG_WIDTH;
      cfg.logical_height  <= rpw_pkg::RST_LOG_HEIGHT;
      cfg.bytes_per_pixel <= rpw_pkg::RST_BPP;
      cfg.row_stride      <= rpw_pkg::RST_ROW_STRIDE;
      cfg.red_format      <= rpw_pkg::RST_RED_FORMAT;
      cfg.green_format    <= rpw_pkg::RST_GREEN_FORMAT;
      cfg.blue_format     <= rpw_pkg::RST_BLUE_FORMAT;
    end else if (wr) begin
      case (sel)
        rpw_pkg::REG_ROTATION:     cfg.rotation        <= pwdata[1:0];
        rpw_pkg::REG_LOG_WIDTH:    cfg.logical_width   <= pwdata[12:0];
        rpw_pkg::REG_LOG_HEIGHT:   cfg.logical_height  <= pwdata[12:0];
        rpw_pkg::REG_BPP:          cfg.bytes_per_pixel <= pwdata[2:0];
        rpw_pkg::REG_ROW_STRIDE:   cfg.row_stride      <= pwdata[14:0];
        rpw_pkg::REG_RED_FORMAT:   cfg.red_format      <= pwdata[8:0];
        rpw_pkg::REG_GREEN_FORMAT: cfg.green_format    <= pwdata[8:0];
        rpw_pkg::REG_BLUE_FORMAT:  cfg.blue_format     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      rpw_pkg::REG_ROTATION:     prdata = {30'd0, cfg.rotation};
      rpw_pkg::REG_LOG_WIDTH:    prdata = {19'd0, cfg.logical_width};
      rpw_pkg::REG_LOG_HEIGHT:   prdata = {19'd0, cfg.logical_height};
      rpw_pkg::REG_BPP:          prdata = {29'd0, cfg.bytes_per_pixel};
      rpw_pkg::REG_ROW_STRIDE:   prdata = {17'd0, cfg.row_stride};
      rpw_pkg::REG_RED_FORMAT:   prdata = {23'd0, cfg.red_format};
      rpw_pkg::REG_GREEN_FORMAT: prdata = {23'd0, cfg.green_format};
      rpw_pkg::REG_BLUE_FORMAT:  prdata = {23'd0, cfg.blue_format};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/rpw_palette.sv
// Palette store: one write and one registered read per cycle, cleared at reset.
`default_nettype none

module rpw_palette (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [rpw_pkg::PAL_AW-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic                      re,
  input  logic [rpw_pkg::PAL_AW-1:0] raddr,
  output logic [31:0]               rdata
);

  logic [31:0]                       mem [rpw_pkg::PALETTE_DEPTH];
  logic [rpw_pkg::PALETTE_DEPTH-1:0] vld;
  logic [31:0]                       rd_q;
  logic                              rd_vld;

  // Per-entry valid bits stand in for the reset clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      if (re) rd_vld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  assign rdata = rd_vld ? rd_q : 32'd0;

endmodule

`default_nettype wire

### rtl/rpw_front.sv
// Input decode: color packing, clipping and rotation into physical row and column.
`default_nettype none

module rpw_front (
  input  rpw_pkg::cfg_t                cfg,
  input  logic                         kind,
  input  logic [rpw_pkg::POS_W-1:0]    pos_x,
  input  logic [rpw_pkg::POS_W-1:0]    pos_y,
  input  logic [rpw_pkg::IDX_W-1:0]    color_index,
  input  logic [23:0]                  rgb_value,
  output rpw_pkg::front_t              fr
);

  logic [rpw_pkg::POS_W:0] x;
  logic [rpw_pkg::POS_W:0] y;
  logic [12:0]             ux;
  logic [12:0]             uy;
  logic                    x_ok;
  logic                    y_ok;
  logic                    idx_ok;
  logic [12:0]             w_rev;
  logic [12:0]             h_rev;
  logic [31:0]             packed_word;

  assign x  = rpw_pkg::coord_value(pos_x);
  assign y  = rpw_pkg::coord_value(pos_y);
  assign ux = 13'(x[rpw_pkg::POS_W-1:0]);
  assign uy = 13'(y[rpw_pkg::POS_W-1:0]);

  assign x_ok   = !x[rpw_pkg::POS_W] && (ux < cfg.logical_width);
  assign y_ok   = !y[rpw_pkg::POS_W] && (uy < cfg.logical_height);
  assign idx_ok = ({1'b0, color_index} < 9'(rpw_pkg::PALETTE_DEPTH));

  assign w_rev = cfg.logical_width - ux - 13'd1;
  assign h_rev = cfg.logical_height - uy - 13'd1;

  always_comb begin
    if (rpw_pkg::eff_bpp(cfg.bytes_per_pixel) == 3'd1) begin
      packed_word = {24'd0, color_index};
    end else begin
      packed_word = rpw_pkg::pack_component(rgb_value[23:16], cfg.red_format)
                  | rpw_pkg::pack_component(rgb_value[15:8],  cfg.green_format)
                  | rpw_pkg::pack_component(rgb_value[7:0],   cfg.blue_format);
    end
  end

  always_comb begin
    fr.pal_we    = (kind == rpw_pkg::KIND_PALETTE) && idx_ok;
    fr.pal_wdata = idx_ok ? packed_word : 32'd0;
    fr.hit       = (kind == rpw_pkg::KIND_DRAW) && x_ok && y_ok && idx_ok;
    case (rpw_pkg::rot_t'(cfg.rotation))
      rpw_pkg::ROT_90: begin
        fr.row = ux;
        fr.col = h_rev;
      end
      rpw_pkg::ROT_180: begin
        fr.row = h_rev;
        fr.col = w_rev;
      end
      rpw_pkg::ROT_270: begin
        fr.row = w_rev;
        fr.col = uy;
      end
      default: begin
        fr.row = uy;
        fr.col = ux;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/rpw_result.sv
// Result stage: byte offset multiply-add and palette word masking for draws; a palette write passes its word through.
`default_nettype none

module rpw_result (
  input  rpw_pkg::cfg_t   cfg,
  input  rpw_pkg::stage_t st,
  input  logic [31:0]     pal_word,
  output logic            access_valid,
  output logic [25:0]     byte_offset,
  output logic [31:0]     pixel_data,
  output logic [2:0]      byte_count,
  output logic            xor_access
);

  logic [2:0]  bpp;
  logic [27:0] row_bytes;
  logic [15:0] col_bytes;
  logic [27:0] sum;

  assign bpp       = rpw_pkg::eff_bpp(cfg.bytes_per_pixel);
  assign row_bytes = {15'd0, st.row} * {13'd0, cfg.row_stride};
  assign col_bytes = {3'd0, st.col} * {13'd0, bpp};
  assign sum       = row_bytes + {12'd0, col_bytes};

  always_comb begin
    access_valid = 1'b0;
    byte_offset  = 26'd0;
    pixel_data   = 32'd0;
    byte_count   = 3'd0;
    xor_access   = 1'b0;
    if (st.kind == rpw_pkg::KIND_PALETTE) begin
      pixel_data = st.wdata;
    end else if (st.hit) begin
      access_valid = 1'b1;
      byte_offset  = sum[25:0];
      pixel_data   = pal_word & rpw_pkg::byte_mask(bpp);
      byte_count   = bpp;
      xor_access   = st.xor_mode;
    end
  end

endmodule

`default_nettype wire

### rtl/rotated_palette_pixel_writer.sv
// Top level of the rotated palette pixel writer.
`default_nettype none
//
// Each input item is either a palette write (kind 0) or a pixel draw (kind 1).
// Input channel: in_valid / in_stall, fields kind, pos_x, pos_y, color_index,
// xor_mode, rgb_value. Output channel: out_valid / out_stall, fields
// access_valid, byte_offset, pixel_data, byte_count, xor_access. Every item
// gives exactly one result item, in order.
// Pipeline: input register (with the palette read registered alongside it),
// then the result register. Throughput is one item per cycle while out_stall
// is low, set by the single palette read port and the one row-times-stride
// multiply in the result stage.
// A palette write lands in the store at the edge that accepts it, so a draw
// right behind it already reads the new word.
// When out_stall holds the result, one more item is still taken into the
// input register; in_stall rises only when both stages are full.
// Reset (rst, synchronous) empties the pipeline, loads the register reset
// values and marks every palette entry as zero through per-entry valid bits,
// so items can be accepted directly after reset.
// Registers sit on an APB-style port at byte address 4*index; pready is
// always high. Write them only while the block is idle.

module rotated_palette_pixel_writer (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [11:0]                 pos_x,
  input  logic [11:0]                 pos_y,
  input  logic [7:0]                  color_index,
  input  logic                        xor_mode,
  input  logic [23:0]                 rgb_value,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        access_valid,
  output logic [25:0]                 byte_offset,
  output logic [31:0]                 pixel_data,
  output logic [2:0]                  byte_count,
  output logic                        xor_access,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rpw_pkg::cfg_t   cfg;
  rpw_pkg::front_t fr;
  rpw_pkg::stage_t st;
  logic            st_valid;
  logic [31:0]     pal_word;
  logic            out_adv;
  logic            accept;

  logic            r_access_valid;
  logic [25:0]     r_byte_offset;
  logic [31:0]     r_pixel_data;
  logic [2:0]      r_byte_count;
  logic            r_xor_access;

  // Output register frees when empty or taken; input register frees when
  // empty or moving on.
  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = st_valid && !out_adv;
  assign accept   = in_valid && !in_stall;

  rpw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpw_front u_front (
    .cfg         (cfg),
    .kind        (kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .color_index (color_index),
    .rgb_value   (rgb_value),
    .fr          (fr)
  );

  // Read data is captured only on acceptance, so it stays with the item.
  rpw_palette u_palette (
    .clk   (clk),
    .rst   (rst),
    .we    (accept && fr.pal_we),
    .waddr (color_index[rpw_pkg::PAL_AW-1:0]),
    .wdata (fr.pal_wdata),
    .re    (accept),
    .raddr (color_index[rpw_pkg::PAL_AW-1:0]),
    .rdata (pal_word)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (!in_stall) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st.kind     <= kind;
      st.hit      <= fr.hit;
      st.row      <= fr.row;
      st.col      <= fr.col;
      st.xor_mode <= xor_mode;
      st.wdata    <= fr.pal_wdata;
    end
  end

  rpw_result u_result (
    .cfg          (cfg),
    .st           (st),
    .pal_word     (pal_word),
    .access_valid (r_access_valid),
    .byte_offset  (r_byte_offset),
    .pixel_data   (r_pixel_data),
    .byte_count   (r_byte_count),
    .xor_access   (r_xor_access)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && st_valid) begin
      access_valid <= r_access_valid;
      byte_offset  <= r_byte_offset;
      pixel_data   <= r_pixel_data;
      byte_count   <= r_byte_count;
      xor_access   <= r_xor_access;
    end
  end

endmodule

`default_nettype wire

### rtl/rpw_checker.sv
// Port-level checker for the rotated palette pixel writer, bound to the top level.
`default_nettype none

module rpw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        access_valid,
  input logic [25:0] byte_offset,
  input logic [31:0] pixel_data,
  input logic [2:0]  byte_count,
  input logic        xor_access
);

  // A held result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_offset) &&
      $stable(pixel_data) && $stable(byte_count) && $stable(access_valid))
    else $error("held result changed");

  // Pipeline is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // Input backs up only behind a stalled, full output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // No access means no address, size or XOR.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !access_valid |->
      byte_count == 3'd0 && byte_offset == 26'd0 && !xor_access)
    else $error("stray fields on result without access");

  // An access always moves one to four bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && access_valid |-> byte_count != 3'd0 && byte_count <= 3'd4)
    else $error("bad byte count");

endmodule

bind rotated_palette_pixel_writer rpw_checker u_rpw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .access_valid (access_valid),
  .byte_offset  (byte_offset),
  .pixel_data   (pixel_data),
  .byte_count   (byte_count),
  .xor_access   (xor_access)
);

`default_nettype wire

### tb/tb_rotated_palette_pixel_writer.sv
// Self-checking testbench for rotated_palette_pixel_writer: directed and random items.
module tb_rotated_palette_pixel_writer;
  timeunit 1ns;
  timeprecision 1ps;

  // One input item and one result item, field for field as on the ports.
  typedef struct packed {
    logic        kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  color_index;
    logic        xor_mode;
    logic [23:0] rgb_value;
  } pixel_item_t;

  typedef struct packed {
    logic        access_valid;
    logic [25:0] byte_offset;
    logic [31:0] pixel_data;
    logic [2:0]  byte_count;
    logic        xor_access;
  } fb_access_t;

  // Scoreboard: its own copy of the registers and the palette. It predicts
  // the access for each accepted item and checks results in order.
  class pixel_access_scoreboard;
    rpw_pkg::cfg_t regs;
    logic [31:0]   palette_words [rpw_pkg::PALETTE_DEPTH];
    fb_access_t    expected_q [$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   pal_writes;
    int unsigned   draws;
    int unsigned   clipped;

    function void reset_state();
      foreach (palette_words[i]) palette_words[i] = '0;
      regs = '{rpw_pkg::RST_ROTATION, rpw_pkg::RST_LOG_WIDTH, rpw_pkg::RST_LOG_HEIGHT,
               rpw_pkg::RST_BPP, rpw_pkg::RST_ROW_STRIDE, rpw_pkg::RST_RED_FORMAT,
               rpw_pkg::RST_GREEN_FORMAT, rpw_pkg::RST_BLUE_FORMAT};
      expected_q.delete();
    endfunction

    function void set_register(rpw_pkg::reg_idx_t r, logic [31:0] v);
      case (r)
        rpw_pkg::REG_ROTATION:     regs.rotation        = v[1:0];
        rpw_pkg::REG_LOG_WIDTH:    regs.logical_width   = v[12:0];
        rpw_pkg::REG_LOG_HEIGHT:   regs.logical_height  = v[12:0];
        rpw_pkg::REG_BPP:          regs.bytes_per_pixel = v[2:0];
        rpw_pkg::REG_ROW_STRIDE:   regs.row_stride      = v[14:0];
        rpw_pkg::REG_RED_FORMAT:   regs.red_format      = v[8:0];
        rpw_pkg::REG_GREEN_FORMAT: regs.green_format    = v[8:0];
        rpw_pkg::REG_BLUE_FORMAT:  regs.blue_format     = v[8:0];
        default: ;
      endcase
    endfunction

    // Values other than 2, 3 and 4 fall back to one byte per pixel.
    function logic [2:0] active_bpp();
      case (regs.bytes_per_pixel)
        3'd2, 3'd3, 3'd4: return regs.bytes_per_pixel;
        default:          return 3'd1;
      endcase
    endfunction

    // Top len bits of the channel, shifted up by the offset; bits past 31 drop.
    function logic [31:0] place_channel(logic [7:0] chan, logic [8:0] fmt);
      int unsigned len;
      logic [63:0] v;
      len = fmt[3:0];
      if (len == 0) return '0;
      if (len > 8) len = 8;
      v = 64'(chan >> (8 - len));
      v = v << fmt[8:4];
      return v[31:0];
    endfunction

    function void note_input(pixel_item_t it);
      fb_access_t  res;
      logic [2:0]  bpp;
      logic [31:0] word;
      logic        idx_ok;
      longint      x, y, w, h, row, col, off;
      res = '0;
      bpp = active_bpp();
      idx_ok = (int'(it.color_index) < rpw_pkg::PALETTE_DEPTH);
      if (it.kind == rpw_pkg::KIND_PALETTE) begin
        pal_writes++;
        if (bpp == 3'd1) word = {24'd0, it.color_index};
        else word = place_channel(it.rgb_value[23:16], regs.red_format)
                  | place_channel(it.rgb_value[15:8], regs.green_format)
                  | place_channel(it.rgb_value[7:0], regs.blue_format);
        if (idx_ok) begin
          palette_words[it.color_index] = word;
          res.pixel_data = word;
        end
      end else begin
        draws++;
        x = $signed(it.pos_x);
        y = $signed(it.pos_y);
        w = regs.logical_width;
        h = regs.logical_height;
        if (x < 0 || x >= w || y < 0 || y >= h) begin
          clipped++;
        end else if (idx_ok) begin
          case (rpw_pkg::rot_t'(regs.rotation))
            rpw_pkg::ROT_90:  begin row = x;         col = h - y - 1; end
            rpw_pkg::ROT_180: begin row = h - y - 1; col = w - x - 1; end
            rpw_pkg::ROT_270: begin row = w - x - 1; col = y;         end
            default:          begin row = y;         col = x;         end
          endcase
          off = row * longint'(regs.row_stride) + col * longint'(bpp);
          res.access_valid = 1'b1;
          res.byte_offset  = off[25:0];
          res.pixel_data   = palette_words[it.color_index] &
                             ((bpp == 3'd4) ? 32'hffff_ffff : ((32'd1 << (8 * bpp)) - 32'd1));
          res.byte_count   = bpp;
          res.xor_access   = it.xor_mode;
        end
      end
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("ERROR result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
    endtask

    task check_result(fb_access_t got);
      fb_access_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", got.pixel_data, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.access_valid !== want.access_valid)
        report_mismatch("access_valid", got.access_valid, want.access_valid);
      if (got.byte_offset !== want.byte_offset)
        report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
      if (got.pixel_data !== want.pixel_data)
        report_mismatch("pixel_data", got.pixel_data, want.pixel_data);
      if (got.byte_count !== want.byte_count)
        report_mismatch("byte_count", got.byte_count, want.byte_count);
      if (got.xor_access !== want.xor_access)
        report_mismatch("xor_access", got.xor_access, want.xor_access);
    endtask

    task flag_leftovers();
      if (expected_q.size() != 0)
        report_mismatch("results never arrived, count", expected_q.size(), 0);
    endtask
  endclass

  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 48;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  color_index;
  logic        xor_mode;
  logic [23:0] rgb_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        access_valid;
  logic [25:0] byte_offset;
  logic [31:0] pixel_data;
  logic [2:0]  byte_count;
  logic        xor_access;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [rpw_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_access_scoreboard sb;
  int unsigned items_sent;
  int unsigned stall_cycles;
  int unsigned rx_burst;
  bit          idle_en = 1'b0;    // random gaps on both sides when set
  logic        hold_long = 1'b0;  // long receiver hold-off for back-pressure

  rotated_palette_pixel_writer dut (.*);

  initial forever #5 clk = ~clk;

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("TIMEOUT: stimulus or results stuck");
    $display("Some tests failed");
    $finish;
  end

  // Monitor. Everything the bench drives changes by nonblocking assignment at
  // the edge, so reads here see the values that the DUT saw at this edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_input(pixel_item_t'{kind, pos_x, pos_y, color_index, xor_mode, rgb_value});
    if (!rst && in_valid && in_stall)
      stall_cycles++;
    if (!rst && out_valid && !out_stall)
      sb.check_result(fb_access_t'{access_valid, byte_offset, pixel_data, byte_count,
                                   xor_access});
  end

  // Receiver: random stall bursts while idling is on, plus the long hold-off
  // whenever hold_long is up.
  always @(posedge clk) begin
    if (hold_long) begin
      out_stall <= 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst  <= rx_burst - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      rx_burst  <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item and return once it has been taken. in_valid stays high
  // into the next call, so back-to-back items follow without a gap.
  task automatic send_item(pixel_item_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {kind, pos_x, pos_y, color_index, xor_mode, rgb_value} <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every result before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB-style write: setup, then access, then idle on the bus.
  task automatic write_reg(rpw_pkg::reg_idx_t r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(r, v);
    @(posedge clk);
  endtask

  task automatic hold_output(int unsigned cycles);
    hold_long <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_long <= 1'b0;
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return $urandom_range(2, 16);
      2:       return 320;
      3:       return 4096;
      4:       return 8191;
      default: return $urandom_range(1, 8191);
    endcase
  endfunction

  function automatic int unsigned pick_stride();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return 640;
      2:       return 16384;
      3:       return 32767;
      default: return $urandom_range(1, 32767);
    endcase
  endfunction

  // Mostly inside the logical span, sometimes right at the edge, sometimes
  // any 12-bit value (negatives included).
  function automatic logic [11:0] pick_coord(int unsigned span);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1: return r[11:0];
      2:    return 12'(span);
      3:    return (span == 0) ? r[11:0] : 12'(span - 1);
      default:
        return (span == 0) ? r[11:0] :
               12'($urandom_range(0, ((span > 2048) ? 2048 : span) - 1));
    endcase
  endfunction

  function automatic pixel_item_t random_item();
    pixel_item_t it;
    logic [31:0] r0, r1;
    r0 = $urandom;
    r1 = $urandom;
    it.kind        = ($urandom_range(0, 3) == 0) ? rpw_pkg::KIND_PALETTE : rpw_pkg::KIND_DRAW;
    it.pos_x       = pick_coord(sb.regs.logical_width);
    it.pos_y       = pick_coord(sb.regs.logical_height);
    // half the indexes from a small set so draws hit freshly written entries
    it.color_index = r1[8] ? r0[31:24] : {5'd0, r1[2:0]};
    it.xor_mode    = r1[4];
    it.rgb_value   = r0[23:0];
    return it;
  endfunction

  function automatic pixel_item_t mk(logic k, int x, int y, int idx, logic xm,
                                     logic [23:0] rgb);
    return pixel_item_t'{k, 12'(x), 12'(y), 8'(idx), xm, rgb};
  endfunction

  // One register setting per phase. Specific phases pin the extremes:
  // largest sizes and stride, zero width, smallest sizes, zero height,
  // zero stride, and a color format with offset 31 / length 0 / length 8.
  task automatic apply_phase_config(int unsigned p);
    int unsigned w, h, s;
    w = pick_size();
    h = pick_size();
    s = pick_stride();
    case (p)
      2: begin w = 8191; h = 8191; s = 32767; end
      3: w = 0;
      5: begin w = 1; h = 1; s = 1; end
      6: h = 0;
      7: s = 0;
      default: ;
    endcase
    write_reg(rpw_pkg::REG_ROTATION, p % 4);
    write_reg(rpw_pkg::REG_LOG_WIDTH, w);
    write_reg(rpw_pkg::REG_LOG_HEIGHT, h);
    write_reg(rpw_pkg::REG_BPP, (p < 8) ? p : $urandom_range(0, 7));
    write_reg(rpw_pkg::REG_ROW_STRIDE, s);
    if (p == 1) begin
      write_reg(rpw_pkg::REG_RED_FORMAT, 9'h1ff);
      write_reg(rpw_pkg::REG_GREEN_FORMAT, 9'h000);
      write_reg(rpw_pkg::REG_BLUE_FORMAT, 9'h108);
    end else if (p % 3 == 0) begin
      write_reg(rpw_pkg::REG_RED_FORMAT, rpw_pkg::RST_RED_FORMAT);
      write_reg(rpw_pkg::REG_GREEN_FORMAT, rpw_pkg::RST_GREEN_FORMAT);
      write_reg(rpw_pkg::REG_BLUE_FORMAT, rpw_pkg::RST_BLUE_FORMAT);
    end else begin
      write_reg(rpw_pkg::REG_RED_FORMAT, $urandom_range(0, 511));
      write_reg(rpw_pkg::REG_GREEN_FORMAT, $urandom_range(0, 511));
      write_reg(rpw_pkg::REG_BLUE_FORMAT, $urandom_range(0, 511));
    end
  endtask

  initial begin
    int unsigned guard;
    sb = new();
    sb.reset_state();
    in_valid    <= 1'b0;
    kind        <= rpw_pkg::KIND_PALETTE;
    pos_x       <= '0;
    pos_y       <= '0;
    color_index <= '0;
    xor_mode    <= 1'b0;
    rgb_value   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    rst         <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings (320x240, RGB565, no rotation).
    // Palette writes with extreme indexes, colors and ignored fields.
    send_item(mk(rpw_pkg::KIND_PALETTE, 0, 0, 0, 1'b0, 24'hffffff));
    send_item(mk(rpw_pkg::KIND_PALETTE, 0, 0, 255, 1'b1, 24'h000000));
    send_item(mk(rpw_pkg::KIND_PALETTE, -2048, 2047, 1, 1'b0, 24'h123456));
    send_item(mk(rpw_pkg::KIND_PALETTE, 2047, -2048, 128, 1'b1, 24'hff00ff));
    // Draws at the corners, with XOR set and clear.
    send_item(mk(rpw_pkg::KIND_DRAW, 0, 0, 0, 1'b0, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, 319, 239, 1, 1'b1, 24'hffffff));
    send_item(mk(rpw_pkg::KIND_DRAW, 0, 239, 128, 1'b0, 24'h000000));
    // Clipped: just outside each edge and at the coordinate extremes.
    send_item(mk(rpw_pkg::KIND_DRAW, -1, 0, 0, 1'b1, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, 0, -1, 0, 1'b0, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, 320, 0, 0, 1'b1, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, 0, 240, 0, 1'b0, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, -2048, -2048, 1, 1'b1, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, 2047, 2047, 1, 1'b0, 24'h000000));
    // Highest index, and an entry never written since reset (reads zero).
    send_item(mk(rpw_pkg::KIND_DRAW, 100, 50, 255, 1'b0, 24'h000000));
    send_item(mk(rpw_pkg::KIND_DRAW, 5, 7, 77, 1'b1, 24'h000000));
    // A draw right behind a write to the same entry sees the new word.
    send_item(mk(rpw_pkg::KIND_PALETTE, 0, 0, 9, 1'b0, 24'ha5a5a5));
    send_item(mk(rpw_pkg::KIND_DRAW, 10, 20, 9, 1'b0, 24'h000000));
    send_item(mk(rpw_pkg::KIND_PALETTE, 0, 0, 9, 1'b0, 24'h5a5a5a));
    send_item(mk(rpw_pkg::KIND_DRAW, 319, 0, 9, 1'b1, 24'h000000));

    // Random phases, each under a fresh register setting. Phase 4 holds the
    // output off long enough that both stages fill and the input stalls; the
    // last two phases run with no gaps at all.
    idle_en <= 1'b1;
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p == NUM_PHASES - 2) idle_en <= 1'b0;
      apply_phase_config(p);
      if (p == 4) fork hold_output(200); join_none
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    in_valid <= 1'b0;
    guard = 0;
    while (sb.results_seen != items_sent && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    sb.flag_leftovers();

    $display("Ran %0d items over %0d register settings: %0d palette writes, %0d draws (%0d clipped).",
             items_sent, NUM_PHASES + 1, sb.pal_writes, sb.draws, sb.clipped);
    $display("Input was held off for %0d cycles; %0d field mismatches.",
             stall_cycles, sb.mismatches);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
